### rtl/core/upd_pkg.sv
// Package for the URL percent decoder: payload words, escape phase and
// character helpers. No dependencies.
package upd_pkg;

  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_PERCENT = 8'h25;
  localparam logic [7:0] CHAR_SPACE   = 8'h20;

  // Output buffer depth; must be a power of two, at least 4.
  localparam int unsigned UPD_FIFO_DEPTH = 8;

  // Most decoded bytes one encoded byte can release.
  localparam int unsigned UPD_MAX_SLOTS = 3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } upd_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } upd_out_t;

  typedef enum logic [1:0] {
    ESC_NONE  = 2'd0,
    ESC_PCT   = 2'd1,
    ESC_DIGIT = 2'd2
  } upd_phase_e;

  function automatic logic is_hex(input logic [7:0] c);
    return ((c >= 8'h30) && (c <= 8'h39)) ||
           ((c >= 8'h41) && (c <= 8'h46)) ||
           ((c >= 8'h61) && (c <= 8'h66));
  endfunction

  function automatic logic [3:0] hex_val(input logic [7:0] c);
    logic [7:0] v;
    v = 8'h00;
    if ((c >= 8'h30) && (c <= 8'h39)) begin
      v = c - 8'h30;
    end else if ((c >= 8'h41) && (c <= 8'h46)) begin
      v = c - 8'h37;
    end else if ((c >= 8'h61) && (c <= 8'h66)) begin
      v = c - 8'h57;
    end
    return v[3:0];
  endfunction

endpackage

### rtl/core/url_percent_decoder_unit.sv
// URL percent decoder top level: input stage, escape decode and output buffer.
// Depends on upd_pkg.
//
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_word_i) carries one encoded
//   byte per word plus a last flag marking the end of a string. Output
//   channel (out_valid_o / out_stall_i / out_word_o) carries decoded bytes;
//   out_last is set on the final decoded byte of each string. A word moves
//   at a clock edge where valid is high and stall is low.
//   "%hh" (either case) collapses to one byte; a broken escape passes the
//   held '%' and digit through unchanged. '+' becomes ' ' while the
//   plus_to_space register (cfg_we_i / cfg_wdata_i) is 1. The last flag
//   flushes any held escape bytes.
// Path: a taken input word is held in the input register, then written to
//   the output buffer; out_valid_o rises once the buffer holds its bytes.
// Throughput: one input word per cycle, sustained while the buffer has room
//   for three bytes; the input stage advances only then. One input may
//   release up to three bytes; the output buffer (FifoDepth entries) absorbs
//   those bursts, and since output never outnumbers input over a string it
//   drains at one byte per cycle while out_stall_i is low.
// Reset: clears the escape state, empties the buffer and the input stage,
//   and sets plus_to_space to 1.
// Stall: a stalled output holds its word; the buffer fills, and once fewer
//   than three entries are free the input stage holds and raises in_stall_o.
module url_percent_decoder_unit #(
  parameter int unsigned FifoDepth = upd_pkg::UPD_FIFO_DEPTH
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic              cfg_wdata_i,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  upd_pkg::upd_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output upd_pkg::upd_out_t out_word_o
);
  import upd_pkg::*;

  localparam int unsigned AW = $clog2(FifoDepth);
  localparam int unsigned CW = $clog2(FifoDepth + 1);
  localparam logic [CW-1:0] RoomLimit = CW'(FifoDepth - UPD_MAX_SLOTS);

  // Configuration
  logic plus_to_space_q;

  // Input stage
  logic    stage_valid_q;
  upd_in_t stage_word_q;
  logic    in_accept;
  logic    room;
  logic    advance;

  // Escape state
  upd_phase_e phase_q, phase_d, phase_mid;
  logic [7:0] held_q, held_d;

  // Decode
  logic [7:0] cur_byte;
  logic       cur_last;
  logic       cur_hex;
  logic       cur_pct;
  logic       idle_emit;
  logic [7:0] idle_byte;
  logic [7:0] decoded;
  logic [7:0] slot_byte [UPD_MAX_SLOTS];
  logic       slot_last [UPD_MAX_SLOTS];
  logic [1:0] slot_cnt;

  // Output buffer
  upd_out_t        buf_mem [FifoDepth];
  logic [AW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]   count_q, count_d;
  logic            pop;

  // ---------------------------------------------------------------------------
  // Configuration register: bit 0 only; the user must write it only while the block is idle, as the block has no guard.
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plus_to_space_q <= 1'b1;
    end else if (cfg_we_i) begin
      plus_to_space_q <= cfg_wdata_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Input stage. Advance into the buffer only when three slots are free, so
  // the stall never waits on the output side in the same cycle.
  // ---------------------------------------------------------------------------
  assign room       = (count_q <= RoomLimit);
  assign advance    = stage_valid_q && room;
  assign in_stall_o = stage_valid_q && !room;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_accept) begin
      stage_valid_q <= 1'b1;
    end else if (advance) begin
      stage_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      stage_word_q <= in_word_i;
    end
  end

  // ---------------------------------------------------------------------------
  // Byte classification for the word in the input stage.
  // ---------------------------------------------------------------------------
  assign cur_byte  = stage_word_q.data_byte;
  assign cur_last  = stage_word_q.last_byte;
  assign cur_hex   = is_hex(cur_byte);
  assign cur_pct   = (cur_byte == CHAR_PERCENT);
  // A byte seen with nothing held: '%' opens an escape, all else is emitted.
  assign idle_emit = !cur_pct;
  assign idle_byte = (plus_to_space_q && (cur_byte == CHAR_PLUS)) ? CHAR_SPACE : cur_byte;
  assign decoded   = {hex_val(held_q), hex_val(cur_byte)};

  // ---------------------------------------------------------------------------
  // Next escape state. phase_mid is the phase before the last flag flushes.
  // ---------------------------------------------------------------------------
  always_comb begin
    held_d = held_q;
    unique case (phase_q)
      ESC_PCT: begin
        if (cur_hex) begin
          phase_mid = ESC_DIGIT;
          held_d    = cur_byte;
        end else begin
          phase_mid = cur_pct ? ESC_PCT : ESC_NONE;
        end
      end
      ESC_DIGIT: begin
        if (cur_hex) begin
          phase_mid = ESC_NONE;
        end else begin
          phase_mid = cur_pct ? ESC_PCT : ESC_NONE;
        end
      end
      default: begin
        phase_mid = cur_pct ? ESC_PCT : ESC_NONE;
      end
    endcase
    phase_d = cur_last ? ESC_NONE : phase_mid;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= ESC_NONE;
      held_q  <= 8'h00;
    end else if (advance) begin
      phase_q <= phase_d;
      held_q  <= held_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Result slots: up to three bytes, filled in order.
  // ---------------------------------------------------------------------------
  always_comb begin
    for (int k = 0; k < UPD_MAX_SLOTS; k++) begin
      slot_byte[k] = 8'h00;
      slot_last[k] = 1'b0;
    end
    slot_cnt = 2'd0;

    unique case (phase_q)
      ESC_PCT: begin
        if (!cur_hex) begin
          slot_byte[slot_cnt] = CHAR_PERCENT;
          slot_cnt            = slot_cnt + 2'd1;
          if (idle_emit) begin
            slot_byte[slot_cnt] = idle_byte;
            slot_cnt            = slot_cnt + 2'd1;
          end
        end
      end
      ESC_DIGIT: begin
        if (cur_hex) begin
          slot_byte[slot_cnt] = decoded;
          slot_cnt            = slot_cnt + 2'd1;
        end else begin
          slot_byte[slot_cnt] = CHAR_PERCENT;
          slot_cnt            = slot_cnt + 2'd1;
          slot_byte[slot_cnt] = held_q;
          slot_cnt            = slot_cnt + 2'd1;
          if (idle_emit) begin
            slot_byte[slot_cnt] = idle_byte;
            slot_cnt            = slot_cnt + 2'd1;
          end
        end
      end
      default: begin
        if (idle_emit) begin
          slot_byte[slot_cnt] = idle_byte;
          slot_cnt            = slot_cnt + 2'd1;
        end
      end
    endcase

    // End of string: flush whatever escape is still held.
    if (cur_last) begin
      if (phase_mid == ESC_PCT) begin
        if (slot_cnt < 2'd3) begin
          slot_byte[slot_cnt] = CHAR_PERCENT;
          slot_cnt            = slot_cnt + 2'd1;
        end
      end else if (phase_mid == ESC_DIGIT) begin
        if (slot_cnt < 2'd2) begin
          slot_byte[slot_cnt] = CHAR_PERCENT;
          slot_cnt            = slot_cnt + 2'd1;
          slot_byte[slot_cnt] = held_d;
          slot_cnt            = slot_cnt + 2'd1;
        end
      end
    end

    for (int k = 0; k < UPD_MAX_SLOTS; k++) begin
      slot_last[k] = cur_last && (slot_cnt == 2'(k + 1));
    end
  end

  // ---------------------------------------------------------------------------
  // Output buffer: push up to three bytes, pop one.
  // ---------------------------------------------------------------------------
  assign out_valid_o = (count_q != '0);
  assign out_word_o  = buf_mem[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;

  always_comb begin
    count_d = count_q;
    if (advance) begin
      count_d = count_d + CW'(slot_cnt);
    end
    if (pop) begin
      count_d = count_d - CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      for (int k = 0; k < UPD_MAX_SLOTS; k++) begin
        if (2'(k) < slot_cnt) begin
          buf_mem[wr_ptr_q + AW'(k)] <= '{out_byte: slot_byte[k], out_last: slot_last[k]};
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (advance) begin
        wr_ptr_q <= wr_ptr_q + AW'(slot_cnt);
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + AW'(1);
      end
      count_q <= count_d;
    end
  end

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(FifoDepth))
    else $error("output buffer count above depth");

  a_last_yields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cur_last |-> slot_cnt != 2'd0)
    else $error("last byte released no decoded byte");

  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && cur_last |=> phase_q == ESC_NONE)
    else $error("escape still held after end of string");

  a_stall_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> count_q >= $past(count_q))
    else $error("buffer drained while output stalled");

endmodule
